// File: rtl/frp_pkg.sv
// Shared types and codes for the frame receive parser.
// No dependencies; compiled first.
package frp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned EventW = 2;

  // Result event codes
  localparam logic [EventW-1:0] EV_NONE = 2'd0;
  localparam logic [EventW-1:0] EV_DATA = 2'd1;
  localparam logic [EventW-1:0] EV_GOOD = 2'd2;
  localparam logic [EventW-1:0] EV_BAD  = 2'd3;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   byte_index;
    logic [LenW-1:0]   frame_length;
  } res_t;

endpackage

// File: rtl/frp_if.sv
// Channel interfaces for the frame receive parser: received bytes,
// results and the frame id write port. Depends on frp_pkg.
interface frp_in_if;
  logic                       valid;
  logic                       ready;
  logic [frp_pkg::ByteW-1:0]  rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frp_out_if;
  logic                        valid;
  logic                        ready;
  logic [frp_pkg::EventW-1:0]  event_res;
  logic [frp_pkg::ByteW-1:0]   data_byte;
  logic [frp_pkg::LenW-1:0]    byte_index;
  logic [frp_pkg::LenW-1:0]    frame_length;
  modport source (output valid, output event_res, output data_byte,
                  output byte_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input data_byte,
                  input byte_index, input frame_length, output ready);
endinterface

interface frp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [frp_pkg::ByteW-1:0]  frame_id;
  modport source (output valid, output frame_id, input ready);
  modport sink   (input valid, input frame_id, output ready);
endinterface

// File: rtl/frp_out_buf.sv
// Output register plus skid stage for parser results.
// Depends on frp_pkg and frp_out_if.
module frp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  frp_pkg::res_t     up_data,
  frp_out_if.source         dn
);

  logic          out_valid;
  frp_pkg::res_t out_data;
  logic          skid_valid;
  frp_pkg::res_t skid_data;

  // Registered ready: upstream only stops once the skid slot is full.
  assign up_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || dn.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= up_valid;
      end
    end else if (up_valid && up_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || dn.ready) begin
      out_data <= skid_valid ? skid_data : up_data;
    end else if (up_valid && up_ready) begin
      skid_data <= up_data;
    end
  end

  assign dn.valid        = out_valid;
  assign dn.event_res    = out_data.event_res;
  assign dn.data_byte    = out_data.data_byte;
  assign dn.byte_index   = out_data.byte_index;
  assign dn.frame_length = out_data.frame_length;

endmodule

// File: rtl/frame_receive_parser_unit.sv
// Frame receive parser top level: id / length / payload / XOR checksum.
// Results are registered: the output register takes each byte's result at its transfer, or the skid slot while stalled.
// Throughput: one byte per cycle; a two-deep result buffer lets the input
//   keep going for one transfer while the output is stalled.
// Reset (rst, synchronous): parser back to hunting, length, count, XOR and
//   frame id cleared, result buffer emptied.
module frame_receive_parser_unit (
  input  logic       clk,
  input  logic       rst,
  frp_in_if.sink     rx,
  frp_out_if.source  result,
  frp_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_DATA   = 3'd3,
    PH_CKSUM  = 3'd4
  } phase_t;

  phase_t                     phase, phase_next;
  logic [frp_pkg::LenW-1:0]   length_reg, length_next;
  logic [frp_pkg::LenW-1:0]   byte_count, byte_count_next;
  logic [frp_pkg::ByteW-1:0]  running_xor, running_xor_next;
  logic [frp_pkg::ByteW-1:0]  frame_id;

  frp_pkg::res_t              res;
  logic                       res_ready;
  logic                       rx_take;

  // Frame id register; always ready. A new id only counts at the next
  // comparison while hunting, so a write mid-frame leaves that frame alone.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id <= '0;
    end else if (cfg.valid) begin
      frame_id <= cfg.frame_id;
    end
  end

  assign rx.ready = res_ready;
  assign rx_take  = rx.valid && res_ready;

  // Per-byte parse step
  always_comb begin
    phase_next       = phase;
    length_next      = length_reg;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    res.event_res    = frp_pkg::EV_NONE;
    res.data_byte    = '0;
    res.byte_index   = '0;
    unique case (phase)
      PH_LEN_LO: begin
        length_next = {{(frp_pkg::LenW-frp_pkg::ByteW){1'b0}}, rx.rx_byte};
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_next = {rx.rx_byte, length_reg[frp_pkg::ByteW-1:0]};
        // zero-length frame skips straight to the checksum byte
        phase_next  = (length_next == '0) ? PH_CKSUM : PH_DATA;
      end
      PH_DATA: begin
        res.event_res    = frp_pkg::EV_DATA;
        res.data_byte    = rx.rx_byte;
        res.byte_index   = byte_count;
        running_xor_next = running_xor ^ rx.rx_byte;
        byte_count_next  = byte_count + 1'b1;
        if (byte_count_next == length_reg) begin
          phase_next = PH_CKSUM;
        end
      end
      PH_CKSUM: begin
        res.event_res = (running_xor == rx.rx_byte) ? frp_pkg::EV_GOOD
                                                     : frp_pkg::EV_BAD;
        phase_next    = PH_HUNT;
      end
      default: begin
        // hunting (and any stray code): look for the id byte
        phase_next = PH_HUNT;
        if (rx.rx_byte == frame_id) begin
          length_next      = '0;
          byte_count_next  = '0;
          running_xor_next = '0;
          phase_next       = PH_LEN_LO;
        end
      end
    endcase
    res.frame_length = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      length_reg  <= '0;
      byte_count  <= '0;
      running_xor <= '0;
    end else if (rx_take) begin
      phase       <= phase_next;
      length_reg  <= length_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
    end
  end

  frp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rx.valid),
    .up_ready (res_ready),
    .up_data  (res),
    .dn       (result)
  );

  // Checks
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_res == frp_pkg::EV_DATA
      |-> result.byte_index < result.frame_length)
    else $error("payload index not below frame length");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_res != frp_pkg::EV_DATA
      |-> result.data_byte == '0 && result.byte_index == '0)
    else $error("data fields not cleared on non-data event");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> result.valid)
    else $error("input stalled with empty output");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    rx_take && phase == PH_HUNT && rx.rx_byte == frame_id
      |=> phase == PH_LEN_LO && byte_count == '0 && running_xor == '0)
    else $error("frame start not taken");

endmodule

// File: tb/tb_frame_receive_parser_unit.sv
`timescale 1ns / 1ps
// Testbench for frame_receive_parser_unit: directed and random byte streams,
// with results predicted and checked in order. Needs frp_pkg and the channel
// interfaces (frp_in_if, frp_out_if, frp_cfg_if) from the RTL.
module tb_frame_receive_parser_unit;

  // Cycles with no transfer on any channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the one long hold-off on the result side
  localparam int LONG_HOLD      = 60;

  typedef logic [frp_pkg::ByteW-1:0] byte_t;
  typedef logic [frp_pkg::LenW-1:0]  len_t;

  // Parser phases as the predictor tracks them
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_DATA   = 3'd3,
    PH_CKSUM  = 3'd4
  } parse_phase_t;

  logic clk;
  logic rst;

  frp_in_if  rx_ch ();
  frp_out_if res_ch ();
  frp_cfg_if cfg_ch ();

  frame_receive_parser_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the parser as the testbench sees it
  // ---------------------------------------------------------------------------
  parse_phase_t       parse_phase;
  len_t               frame_len_q;
  len_t               payload_count;
  byte_t              payload_xor;
  byte_t              match_id;      // frame id as the block holds it

  frp_pkg::res_t      expected_results[$];
  int                 err_count = 0;

  // Stimulus side
  byte_t              stim_id = '0;  // id the stimulus opens frames with
  int                 src_idle_pct  = 0;
  int                 sink_idle_pct = 0;
  logic               hold_req;
  int                 bytes_sent = 0;

  // ---------------------------------------------------------------------------
  // Clock generation; reset is driven from the sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the parser by one byte and give the result that byte causes.
  function automatic frp_pkg::res_t parse_rx_byte(input byte_t b);
    frp_pkg::res_t r;
    r = '0;
    r.event_res = frp_pkg::EV_NONE;
    case (parse_phase)
      PH_LEN_LO: begin
        frame_len_q = {8'h00, b};
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len_q[15:8] = b;
        // zero length skips straight to the checksum byte
        parse_phase = (frame_len_q == '0) ? PH_CKSUM : PH_DATA;
      end
      PH_DATA: begin
        r.event_res  = frp_pkg::EV_DATA;
        r.data_byte  = b;
        r.byte_index = payload_count;
        payload_xor  = payload_xor ^ b;
        payload_count = payload_count + 1'b1;
        if (payload_count == frame_len_q) parse_phase = PH_CKSUM;
      end
      PH_CKSUM: begin
        r.event_res = (payload_xor == b) ? frp_pkg::EV_GOOD : frp_pkg::EV_BAD;
        parse_phase = PH_HUNT;
      end
      default: begin
        // hunting (unused codes behave the same): a matching id opens a frame
        // and clears length, count and XOR
        parse_phase = PH_HUNT;
        if (b == match_id) begin
          frame_len_q   = '0;
          payload_count = '0;
          payload_xor   = '0;
          parse_phase   = PH_LEN_LO;
        end
      end
    endcase
    r.frame_length = frame_len_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, seen);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: id writes, byte transfers and result transfers, all sampled at
  // the rising edge. Prediction is pushed before the check so ordering holds
  // whatever the block's latency. A byte taken at the edge of an id write
  // still sees the old id.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    frp_pkg::res_t want;
    if (rst) begin
      parse_phase   = PH_HUNT;
      frame_len_q   = '0;
      payload_count = '0;
      payload_xor   = '0;
      match_id      = '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready)
        expected_results.push_back(parse_rx_byte(rx_ch.rx_byte));
      if (cfg_ch.valid && cfg_ch.ready) match_id = cfg_ch.frame_id;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: result transfer with nothing expected, actual ev %h data %h",
                   $time, res_ch.event_res, res_ch.data_byte);
        end else begin
          want = expected_results.pop_front();
          check_field("event_res",    16'(want.event_res), 16'(res_ch.event_res));
          check_field("data_byte",    16'(want.data_byte), 16'(res_ch.data_byte));
          check_field("byte_index",   want.byte_index,     res_ch.byte_index);
          check_field("frame_length", want.frame_length,   res_ch.frame_length);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off counted here when the
  // test asks for it, so the block fills and pushes back on the byte input.
  // ---------------------------------------------------------------------------
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = LONG_HOLD;
      hold_taken = 1'b1;
    end else if (!hold_req) begin
      hold_taken = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks. Every task starts and ends at a rising edge.
  // ---------------------------------------------------------------------------

  // One byte transfer; valid stays high on return unless the next call idles.
  task automatic send_byte(input byte_t b);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  // Stop offering bytes and wait until every predicted result has come back.
  // The first edge makes sure the last transfer has been predicted.
  task automatic wait_results_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Frame id write, only with the block idle
  task automatic write_frame_id(input byte_t id);
    wait_results_drained();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.frame_id <= id;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    stim_id = id;
  endtask

  // Whole frame with random payload; a bad checksum flips at least one bit
  task automatic send_frame(input len_t len, input bit good);
    byte_t x;
    byte_t b;
    x = '0;
    send_byte(stim_id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(255));
      x ^= b;
      send_byte(b);
    end
    send_byte(good ? x : x ^ 8'($urandom_range(255, 1)));
  endtask

  // Noise byte that cannot open a frame, so long random lengths never start
  function automatic byte_t non_id_byte();
    byte_t b;
    do b = 8'($urandom_range(255)); while (b == stim_id);
    return b;
  endfunction

  // Mostly short frames, some medium, a few with a non-zero high length byte
  function automatic len_t pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 70) return len_t'($urandom_range(8));
    if (p < 95) return len_t'($urandom_range(64, 9));
    return len_t'($urandom_range(600, 256));
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Bytes that do not match the id while hunting give no event
  task automatic test_hunting_noise();
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  // Reset id 0, zero length straight to checksum, checksum 0 is good
  task automatic test_zero_length();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // Id 0xFF, two payload bytes XOR to 0xFF, checksum 0x00 is bad
  task automatic test_bad_checksum();
    write_frame_id(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
  endtask

  // New id written while a frame is open: the frame finishes normally and the
  // new id only counts once hunting again
  task automatic test_id_change_mid_frame();
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    write_frame_id(8'h5A);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  // Result side held off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      <= 1'b1;
    send_frame(len_t'(40), 1'b1);
    hold_req      <= 1'b0;
  endtask

  // Random frames, corrupted checksums and noise runs at one idle setting
  task automatic test_random_frames(input int src_pct, input int sink_pct,
                                    input byte_t id, input int n_bytes);
    int target;
    write_frame_id(id);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_frame(pick_length(), $urandom_range(3) != 0);
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(non_id_byte());
      end
    end
  endtask

  // Payload past 255 bytes: high length byte in use, index beyond eight bits
  task automatic test_long_frame();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_frame(16'h012C, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    hold_req        <= 1'b0;
    rx_ch.valid     <= 1'b0;
    rx_ch.rx_byte   <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.frame_id <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_hunting_noise();
    test_zero_length();
    test_bad_checksum();
    test_id_change_mid_frame();

    // sender sparse on gaps, receiver often stalled; then the reverse; then flat out
    test_random_frames(20, 73, 8'hFF, 500);
    test_random_frames(73, 20, 8'h00, 500);
    test_backpressure();
    test_random_frames(0, 0, 8'($urandom_range(254, 1)), 500);
    test_long_frame();

    wait_results_drained();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
